// ===== src/ewds_pkg.sv =====
// shared types and constants for the encoder wrap-delta speed block
package ewds_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR_RATIO_Q8  = 1'b1;

  localparam logic [15:0] CPR_RESET  = 16'd1024;
  localparam logic [15:0] GEAR_RESET = 16'd7680;

  // operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // 60 s * 1000 ms, and 1000 ms * 2^8
  localparam logic [15:0] RPM_K = 16'd60000;
  localparam logic [17:0] CPS_K = 18'd256000;

  // shared divider
  localparam int unsigned DIV_W = 48;
  localparam int unsigned CNT_W = $clog2(DIV_W);

  // job queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic        clear;
    logic [16:0] delta;
    logic        reverse;
    logic [15:0] sample_ms;
  } job_t;

  typedef struct packed {
    logic [15:0] counts_per_rev;
    logic [15:0] gear_ratio_q8;
  } cfg_t;

  typedef struct packed {
    logic [33:0] speed_cps_q8;
    logic [39:0] speed_rpm_q8;
    logic        reverse;
    logic [16:0] position_delta;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL1,
    BK_MUL2,
    BK_DIV_RPM,
    BK_DIV_CPS,
    BK_DONE
  } bk_state_e;

endpackage

// ===== src/ewds_front.sv =====
// front end: takes items, forms the wrap-corrected delta and direction, queues a job
module ewds_front #(
  parameter int unsigned COUNTER_PERIOD = 65536
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          operation_i,
  input  logic [15:0]   counter_value_i,
  input  logic [15:0]   sample_ms_i,
  input  logic          full_i,
  output logic          push_o,
  output ewds_pkg::job_t job_o
);
  import ewds_pkg::*;

  localparam logic signed [18:0] PERIOD_S    = 19'(COUNTER_PERIOD);
  localparam logic signed [18:0] HALF_S      = 19'(COUNTER_PERIOD / 2);
  localparam logic signed [18:0] DELTA_MIN_S = -19'sd32768;
  localparam logic signed [18:0] DELTA_MAX_S = 19'sd32768;

  logic [15:0] prev_q, prev_d;
  logic        dir_q, dir_d;

  logic signed [18:0] cur, prev, diff, wrapped, sat;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cur  = {{3{counter_value_i[15]}}, counter_value_i};
    prev = {{3{prev_q[15]}}, prev_q};
    diff = cur - prev;
    wrapped = diff;
    if (diff < 0) begin
      if (-diff > HALF_S) wrapped = diff + PERIOD_S;
    end else begin
      if (diff > HALF_S) wrapped = diff - PERIOD_S;
    end
    sat = wrapped;
    if (wrapped < DELTA_MIN_S) sat = DELTA_MIN_S;
    if (wrapped > DELTA_MAX_S) sat = DELTA_MAX_S;

    prev_d = prev_q;
    dir_d  = dir_q;
    job_o.sample_ms = sample_ms_i;
    if (operation_i == OP_CLEAR) begin
      prev_d        = '0;
      job_o.clear   = 1'b1;
      job_o.delta   = '0;
      job_o.reverse = dir_q;
    end else begin
      prev_d = counter_value_i;
      if (sat > 0) begin
        dir_d = 1'b0;
      end else if (sat < 0) begin
        dir_d = 1'b1;
      end
      job_o.clear   = 1'b0;
      job_o.delta   = sat[16:0];
      job_o.reverse = dir_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      dir_q  <= 1'b0;
    end else if (push_o) begin
      prev_q <= prev_d;
      dir_q  <= dir_d;
    end
  end

endmodule

// ===== src/ewds_fifo.sv =====
// short job queue between the front and back ends
module ewds_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ewds_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ewds_pkg::job_t job_o
);
  import ewds_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = (count_q == (QPTR_W+1)'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/ewds_div.sv =====
// shift-subtract unsigned divider, one quotient bit per cycle
module ewds_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ewds_pkg::DIV_W-1:0] num_i,
  input  logic [ewds_pkg::DIV_W-1:0] den_i,
  output logic                       done_o,
  output logic [ewds_pkg::DIV_W-1:0] quo_o
);
  import ewds_pkg::*;

  logic [DIV_W-1:0] rem_q, quo_q, den_q;
  logic [DIV_W-1:0] rem_d, quo_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [DIV_W:0]   rem_sh;
  logic [DIV_W+1:0] sub;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_W-1]};
    sub    = {1'b0, rem_sh} - {2'b00, den_q};
    if (!sub[DIV_W+1]) begin
      rem_d = sub[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== src/ewds_back.sv =====
// back end: scales and divides one job at a time, holds the result item
module ewds_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ewds_pkg::cfg_t cfg_i,
  input  logic           job_valid_i,
  input  ewds_pkg::job_t job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ewds_pkg::res_t res_o
);
  import ewds_pkg::*;

  bk_state_e   state_q, state_d;
  job_t        job_q, job_d;
  logic [15:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic [31:0] prod_q, prod_d;
  logic [31:0] num_rpm_q, num_rpm_d;
  logic        zero_q, zero_d;
  logic [39:0] rpm_q, rpm_d;
  logic [33:0] cps_q, cps_d;
  logic        out_valid_q, out_valid_d;
  res_t        res_q, res_d;

  logic             div_start, div_done;
  logic [DIV_W-1:0] div_num, div_den, div_quo;
  logic [16:0]      mag_full;
  logic [33:0]      num_cps;

  ewds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign mag_full = job_i.delta[16] ? (17'd0 - job_i.delta) : job_i.delta;
  assign num_cps  = {18'd0, mag_q} * {16'd0, CPS_K};

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    prod_d      = prod_q;
    num_rpm_d   = num_rpm_q;
    zero_d      = zero_q;
    rpm_d       = rpm_q;
    cps_d       = cps_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          pop_o = 1'b1;
          job_d = job_i;
          neg_d = job_i.delta[16];
          mag_d = mag_full[15:0];
          if (job_i.clear) begin
            rpm_d   = '0;
            cps_d   = '0;
            state_d = BK_DONE;
          end else begin
            state_d = BK_MUL1;
          end
        end
      end
      BK_MUL1: begin
        prod_d    = {16'd0, cfg_i.counts_per_rev} * {16'd0, cfg_i.gear_ratio_q8};
        num_rpm_d = {16'd0, mag_q} * {16'd0, RPM_K};
        state_d   = BK_MUL2;
      end
      BK_MUL2: begin
        div_start = 1'b1;
        div_num   = {num_rpm_q, 16'd0};
        div_den   = {16'd0, prod_q} * {32'd0, job_q.sample_ms};
        zero_d    = (prod_q == '0) || (job_q.sample_ms == '0);
        state_d   = BK_DIV_RPM;
      end
      BK_DIV_RPM: begin
        if (div_done) begin
          if (zero_q) begin
            rpm_d = '0;
          end else if (neg_q) begin
            rpm_d = 40'd0 - div_quo[39:0];
          end else begin
            rpm_d = div_quo[39:0];
          end
          div_start = 1'b1;
          div_num   = {14'd0, num_cps};
          div_den   = {32'd0, job_q.sample_ms};
          zero_d    = (job_q.sample_ms == '0);
          state_d   = BK_DIV_CPS;
        end
      end
      BK_DIV_CPS: begin
        if (div_done) begin
          if (zero_q) begin
            cps_d = '0;
          end else if (neg_q) begin
            cps_d = 34'd0 - div_quo[33:0];
          end else begin
            cps_d = div_quo[33:0];
          end
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        // wait for the output slot, then hand the item over
        if (!out_valid_q || out_ready_i) begin
          res_d.position_delta = job_q.delta;
          res_d.reverse        = job_q.reverse;
          res_d.speed_rpm_q8   = rpm_q;
          res_d.speed_cps_q8   = cps_q;
          out_valid_d          = 1'b1;
          state_d              = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    job_q     <= job_d;
    mag_q     <= mag_d;
    neg_q     <= neg_d;
    prod_q    <= prod_d;
    num_rpm_q <= num_rpm_d;
    zero_q    <= zero_d;
    rpm_q     <= rpm_d;
    cps_q     <= cps_d;
    res_q     <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== src/encoder_wrap_delta_speed.sv =====
// top level: encoder wrap-aware delta and speed measurement
//
//   channel   dir  width  contents
//   s_axis    in   32+1   tdata: counter_value, sample_ms; tuser: operation
//   m_axis    out  96     tdata: position_delta, reverse, speed_rpm_q8, speed_cps_q8
//   cfg       in   1+16   register write, no read-back
//
// a sample item's result comes from two 48-step shift-subtract divisions on one
// shared divider (rpm, then counts per second); a clear item skips the divider
// and goes straight to the result; the front end takes an item per cycle, as
// long as the queue is not full, into a two-entry job queue while the back end
// works or its result waits
// rst_ni clears the stored reading, direction, queue and back-end state
module encoder_wrap_delta_speed #(
  parameter int unsigned COUNTER_PERIOD = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // counter_value[15:0], sample_ms[31:16]
  input  logic [0:0]  s_axis_tuser,   // operation[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // position_delta[16:0], reverse[17], speed_rpm_q8[57:18],
  // speed_cps_q8[91:58], zero[95:92]
  output logic [95:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [ewds_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import ewds_pkg::*;

  cfg_t cfg_q;
  job_t front_job, queue_job;
  res_t res;
  logic push, full, pop, job_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.counts_per_rev <= CPR_RESET;
      cfg_q.gear_ratio_q8  <= GEAR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_COUNTS_PER_REV: cfg_q.counts_per_rev <= cfg_data_i;
        CFG_GEAR_RATIO_Q8:  cfg_q.gear_ratio_q8  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ewds_front #(
    .COUNTER_PERIOD(COUNTER_PERIOD)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .operation_i    (s_axis_tuser[0]),
    .counter_value_i(s_axis_tdata[15:0]),
    .sample_ms_i    (s_axis_tdata[31:16]),
    .full_i         (full),
    .push_o         (push),
    .job_o          (front_job)
  );

  ewds_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (front_job),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(job_valid),
    .job_o  (queue_job)
  );

  ewds_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_valid_i(job_valid),
    .job_i      (queue_job),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {4'd0, res.speed_cps_q8, res.speed_rpm_q8, res.reverse,
                         res.position_delta};

endmodule
